### design/edfs_pkg.sv
package edfs_pkg;

    // Default sizes of the task table and of the stored time values.
    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    // Fixed widths of the request and response fields.
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 4;
    localparam int FIELD_W   = 16;
    localparam int CNT_W     = 5;
    localparam int CLOCK_W   = 32;
    localparam int RUN_W     = 5;
    localparam int FRAC_BITS = 16;

    // Utilization of exactly 1.0 in the 16 fraction bit format.
    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Reset value of the task count register.
    localparam logic [CNT_W-1:0] TASK_COUNT_RST = CNT_W'(1);

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CHECK = 2'd2
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHK_RD,
        ST_CHK_EVAL,
        ST_CHK_DIV,
        ST_RESULT
    } t_state;

    // Status of the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

### design/edfs_req_if.sv
interface edfs_req_if;

    logic                               valid;
    logic                               ready;
    logic [edfs_pkg::OP_W-1:0]          operation;
    logic [edfs_pkg::SLOT_W-1:0]        slot;
    logic [edfs_pkg::FIELD_W-1:0]       arrival;
    logic [edfs_pkg::FIELD_W-1:0]       exec_units;
    logic [edfs_pkg::FIELD_W-1:0]       deadline;

    modport source (output valid, operation, slot, arrival, exec_units, deadline, input ready);
    modport sink   (input valid, operation, slot, arrival, exec_units, deadline, output ready);

endinterface

### design/edfs_rsp_if.sv
interface edfs_rsp_if;

    logic                               valid;
    logic                               ready;
    logic [edfs_pkg::RUN_W-1:0]         running_task;
    logic                               idle;
    logic                               task_finished;
    logic                               all_finished;
    logic [edfs_pkg::CLOCK_W-1:0]       current_time;
    logic                               feasible;

    modport source (output valid, running_task, idle, task_finished, all_finished,
                    current_time, feasible, input ready);
    modport sink   (input valid, running_task, idle, task_finished, all_finished,
                    current_time, feasible, output ready);

endinterface

### design/edfs_cfg_if.sv
interface edfs_cfg_if;

    logic                               valid;
    logic                               ready;
    logic [edfs_pkg::CNT_W-1:0]         task_count;

    modport source (output valid, task_count, input ready);
    modport sink   (input valid, task_count, output ready);

endinterface

### design/edfs_ram.sv
module edfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/edfs_div.sv
module edfs_div #(
    parameter int DW = 16,
    parameter int QW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [QW-1:0]       i_dividend,
    input  logic [DW-1:0]       i_divisor,
    output logic [QW-1:0]       o_quotient,
    output edfs_pkg::t_div_sts  o_sts
);

    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        trial = {r_rem, r_q[QW-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
    end

    // Control: a count of remaining quotient bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits leave the top while quotient bits enter the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[QW-2:0], fits};
            r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_quotient = r_q;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

### design/edf_task_scheduler_top.sv
// Earliest-deadline-first scheduler over a table of MAX_TASKS task slots. Each request
// gives exactly one response, and one request is handled at a time. A load (or the unused
// code) goes straight from idle to the result state. A tick visits the n slots in use:
// the task table is read one slot per cycle through a registered memory port and each
// entry goes through one deadline comparator. A check runs each slot in use through the
// bit-serial divider, which works on DW-bit values, where DW is TIME_BITS capped at 16,
// and forms execution time * 2^16 / deadline for each slot; it ends early on a zero
// deadline or once the sum exceeds 1.0. The response sits in an output register, so the
// next request can be taken while the last response waits; a second response held back
// by a stalled receiver keeps the block busy until the first one is taken. The table
// holds no valid state: reading a slot that was never loaded gives undefined task
// values.
module edf_task_scheduler_top #(
    parameter int MAX_TASKS = edfs_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = edfs_pkg::TIME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    edfs_cfg_if.sink   i_cfg,
    edfs_req_if.sink   i_req,
    edfs_rsp_if.source o_rsp
);

    localparam int DW = (TIME_BITS < edfs_pkg::FIELD_W) ? TIME_BITS : edfs_pkg::FIELD_W;
    localparam int QW = DW + edfs_pkg::FRAC_BITS;
    localparam int AW = $clog2(MAX_TASKS);
    localparam int NW = $clog2(MAX_TASKS + 1);
    localparam int SW = edfs_pkg::FRAC_BITS + 1;
    localparam int TW = edfs_pkg::CLOCK_W;

    edfs_pkg::t_state r_state, n_state;

    logic [edfs_pkg::CNT_W-1:0] r_task_count;
    logic [MAX_TASKS-1:0]       r_done;
    logic [TW-1:0]              r_time;

    logic [NW-1:0] r_idx;
    logic [AW-1:0] r_pidx;
    logic          r_pend;
    logic          r_best_v;
    logic [AW-1:0] r_best_idx;
    logic [DW-1:0] r_best_dl;
    logic [DW-1:0] r_best_rem;
    logic [SW-1:0] r_sum;

    logic [edfs_pkg::RUN_W-1:0] r_run;
    logic                       r_idle;
    logic                       r_fin;
    logic                       r_feas;

    logic                       r_out_valid;
    logic [edfs_pkg::RUN_W-1:0] r_out_run;
    logic                       r_out_idle;
    logic                       r_out_fin;
    logic                       r_out_all;
    logic [TW-1:0]              r_out_time;
    logic                       r_out_feas;

    logic [NW-1:0]   n_in_use;
    logic            accept;
    logic            in_range;
    logic [AW-1:0]   load_addr;
    logic [DW-1:0]   load_arr;
    logic [DW-1:0]   load_exec;
    logic [DW-1:0]   load_dl;
    logic            scan_end;
    logic            rsp_load;
    logic            all_fin;
    logic [MAX_TASKS-1:0] done_or_unused;

    logic            st_we;
    logic            rm_we;
    logic [AW-1:0]   rm_waddr;
    logic [DW-1:0]   rm_wdata;
    logic [AW-1:0]   raddr;
    logic [3*DW-1:0] st_rdata;
    logic [DW-1:0]   rm_rdata;
    logic [DW-1:0]   rd_arr;
    logic [DW-1:0]   rd_exec;
    logic [DW-1:0]   rd_dl;
    logic            eligible;
    logic            better;

    logic               div_start;
    logic [QW-1:0]      div_q;
    edfs_pkg::t_div_sts div_sts;
    logic [QW:0]        sum_next;
    logic               over;

    // Slots in use: the task count, capped at the table size.
    always_comb begin
        if (32'(r_task_count) > MAX_TASKS) begin
            n_in_use = NW'(MAX_TASKS);
        end else begin
            n_in_use = NW'(r_task_count);
        end
    end

    // Request decode and load values masked to the stored width.
    always_comb begin
        accept    = i_req.valid && i_req.ready;
        in_range  = (32'(i_req.slot) < MAX_TASKS);
        load_addr = AW'(i_req.slot);
        load_arr  = DW'(i_req.arrival);
        load_exec = DW'(i_req.exec_units);
        load_dl   = DW'(i_req.deadline);
    end

    // Fields of the table row read in the previous cycle.
    always_comb begin
        rd_arr   = st_rdata[3*DW-1:2*DW];
        rd_exec  = st_rdata[2*DW-1:DW];
        rd_dl    = st_rdata[DW-1:0];
        eligible = !r_done[r_pidx] && (rm_rdata != '0) && (TW'(rd_arr) <= r_time);
        better   = !r_best_v || (rd_dl < r_best_dl);
    end

    // Running utilization sum; anything above 1.0 ends the check as infeasible.
    always_comb begin
        sum_next = (QW+1)'(r_sum) + (QW+1)'(div_q);
        over     = (sum_next > (QW+1)'(edfs_pkg::FRAC_ONE));
    end

    // Every slot in use is done; slots beyond the count do not matter.
    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            done_or_unused[i] = r_done[i] || (32'(i) >= 32'(n_in_use));
        end
        all_fin = &done_or_unused;
    end

    assign scan_end = (r_state == edfs_pkg::ST_SCAN) && (r_idx == n_in_use) && !r_pend;
    assign rsp_load = (r_state == edfs_pkg::ST_RESULT) && (!r_out_valid || o_rsp.ready);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            edfs_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_req.operation)
                        edfs_pkg::OP_TICK:  n_state = edfs_pkg::ST_SCAN;
                        edfs_pkg::OP_CHECK: n_state = edfs_pkg::ST_CHK_RD;
                        default:            n_state = edfs_pkg::ST_RESULT;
                    endcase
                end
            end
            edfs_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = edfs_pkg::ST_RESULT;
                end
            end
            edfs_pkg::ST_CHK_RD: begin
                if (r_idx == n_in_use) begin
                    n_state = edfs_pkg::ST_RESULT;
                end else begin
                    n_state = edfs_pkg::ST_CHK_EVAL;
                end
            end
            edfs_pkg::ST_CHK_EVAL: begin
                if (rd_dl == '0) begin
                    n_state = edfs_pkg::ST_RESULT;
                end else begin
                    n_state = edfs_pkg::ST_CHK_DIV;
                end
            end
            edfs_pkg::ST_CHK_DIV: begin
                if (div_sts.done) begin
                    n_state = over ? edfs_pkg::ST_RESULT : edfs_pkg::ST_CHK_RD;
                end
            end
            edfs_pkg::ST_RESULT: begin
                if (rsp_load) begin
                    n_state = edfs_pkg::ST_IDLE;
                end
            end
            default: n_state = edfs_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, memory ports and divider start.
    always_comb begin
        i_req.ready = (r_state == edfs_pkg::ST_IDLE);
        i_cfg.ready = 1'b1;
        raddr       = r_idx[AW-1:0];
        st_we       = 1'b0;
        rm_we       = 1'b0;
        rm_waddr    = load_addr;
        rm_wdata    = load_exec;
        div_start   = 1'b0;
        case (r_state)
            edfs_pkg::ST_IDLE: begin
                if (accept && (i_req.operation == edfs_pkg::OP_LOAD) && in_range) begin
                    st_we = 1'b1;
                    rm_we = 1'b1;
                end
            end
            edfs_pkg::ST_SCAN: begin
                if (scan_end && r_best_v) begin
                    rm_we    = 1'b1;
                    rm_waddr = r_best_idx;
                    rm_wdata = r_best_rem - DW'(1);
                end
            end
            edfs_pkg::ST_CHK_EVAL: begin
                div_start = (rd_dl != '0);
            end
            default: begin
            end
        endcase
    end

    // State register and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= edfs_pkg::ST_IDLE;
            r_task_count <= edfs_pkg::TASK_COUNT_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_task_count <= i_cfg.task_count;
            end
        end
    end

    // Done marks and the time counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_time <= '0;
        end else begin
            if (st_we) begin
                r_done[load_addr] <= (load_exec == '0);
            end
            if (scan_end) begin
                if (r_best_v && (r_best_rem == DW'(1))) begin
                    r_done[r_best_idx] <= 1'b1;
                end
                if (r_time != '1) begin
                    r_time <= r_time + TW'(1);
                end
            end
        end
    end

    // Scan and check datapath: slot index, best candidate and utilization sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            case (r_state)
                edfs_pkg::ST_IDLE: begin
                    r_idx    <= '0;
                    r_pend   <= 1'b0;
                    r_best_v <= 1'b0;
                    r_sum    <= '0;
                    r_run    <= '0;
                    r_idle   <= 1'b0;
                    r_fin    <= 1'b0;
                    r_feas   <= (i_req.operation == edfs_pkg::OP_CHECK);
                end
                edfs_pkg::ST_SCAN: begin
                    if (r_idx != n_in_use) begin
                        r_idx  <= r_idx + NW'(1);
                        r_pidx <= r_idx[AW-1:0];
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && eligible && better) begin
                        r_best_v   <= 1'b1;
                        r_best_idx <= r_pidx;
                        r_best_dl  <= rd_dl;
                        r_best_rem <= rm_rdata;
                    end
                    if (scan_end) begin
                        if (r_best_v) begin
                            r_run <= edfs_pkg::RUN_W'(r_best_idx) + edfs_pkg::RUN_W'(1);
                            r_fin <= (r_best_rem == DW'(1));
                        end else begin
                            r_idle <= 1'b1;
                        end
                    end
                end
                edfs_pkg::ST_CHK_EVAL: begin
                    if (rd_dl == '0) begin
                        r_feas <= 1'b0;
                    end
                end
                edfs_pkg::ST_CHK_DIV: begin
                    if (div_sts.done) begin
                        r_sum <= sum_next[SW-1:0];
                        r_idx <= r_idx + NW'(1);
                        if (over) begin
                            r_feas <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register between the sequencer and the response channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_load) begin
            r_out_run  <= r_run;
            r_out_idle <= r_idle;
            r_out_fin  <= r_fin;
            r_out_all  <= all_fin;
            r_out_time <= r_time;
            r_out_feas <= r_feas;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.running_task  = r_out_run;
    assign o_rsp.idle          = r_out_idle;
    assign o_rsp.task_finished = r_out_fin;
    assign o_rsp.all_finished  = r_out_all;
    assign o_rsp.current_time  = r_out_time;
    assign o_rsp.feasible      = r_out_feas;

    // Static task values: arrival, execution time and deadline in one row.
    edfs_ram #(
        .WIDTH (3 * DW),
        .DEPTH (MAX_TASKS)
    ) u_static_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (load_addr),
        .i_wdata ({load_arr, load_exec, load_dl}),
        .i_raddr (raddr),
        .o_rdata (st_rdata)
    );

    // Remaining execution time, written by loads and by the task run at a tick.
    edfs_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TASKS)
    ) u_remain_ram (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (rm_waddr),
        .i_wdata (rm_wdata),
        .i_raddr (raddr),
        .o_rdata (rm_rdata)
    );

    // Bit-serial divider for the per-slot utilization.
    edfs_div #(
        .DW (DW),
        .QW (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({rd_exec, {edfs_pkg::FRAC_BITS{1'b0}}}),
        .i_divisor  (rd_dl),
        .o_quotient (div_q),
        .o_sts      (div_sts)
    );

    // Every accepted request leaves the idle state on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != edfs_pkg::ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // Time never runs backward.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_time >= $past(r_time)))
        else $error("time counter decreased");

    // The divider is started only when it is free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    // A division in flight always belongs to a slot in use.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == edfs_pkg::ST_CHK_DIV) |-> (r_idx < n_in_use))
        else $error("division for a slot beyond the task count");

endmodule

### bench/edfs_sched_checker.sv
// Watches the configuration, request and response channels of the EDF scheduler,
// predicts one response per accepted request and compares it field by field.
module edfs_sched_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    edfs_cfg_if         cfg,
    edfs_req_if         req,
    edfs_rsp_if         rsp,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = edfs_pkg::MAX_TASKS_DEF;
    localparam int FW    = edfs_pkg::FIELD_W;
    localparam int CW    = edfs_pkg::CLOCK_W;

    typedef struct packed {
        logic [edfs_pkg::RUN_W-1:0] running_task;
        logic                       idle;
        logic                       task_finished;
        logic                       all_finished;
        logic [CW-1:0]              current_time;
        logic                       feasible;
    } t_sched_rsp;

    // Shadow copy of the task table, the clock and the task count register.
    logic [FW-1:0]              arrival_tbl   [NSLOT];
    logic [FW-1:0]              exec_tbl      [NSLOT];
    logic [FW-1:0]              deadline_tbl  [NSLOT];
    logic [FW-1:0]              remaining_tbl [NSLOT];
    logic [NSLOT-1:0]           done_mask;
    logic [CW-1:0]              sched_time;
    logic [edfs_pkg::CNT_W-1:0] task_count_q;

    // Responses still owed by the block, oldest first.
    t_sched_rsp expected_rsp_q [$];

    // Applies one request to the shadow state and returns the response it should give.
    function automatic t_sched_rsp schedule_request(
        input logic [edfs_pkg::OP_W-1:0]   op,
        input logic [edfs_pkg::SLOT_W-1:0] slot,
        input logic [FW-1:0]               arr,
        input logic [FW-1:0]               ex,
        input logic [FW-1:0]               dl
    );
        t_sched_rsp  r;
        int unsigned used;
        int unsigned done_cnt;
        int          pick;
        logic [63:0] util_sum;
        logic        zero_dl;
        r = '0;
        used = (task_count_q > NSLOT) ? NSLOT : task_count_q;
        case (op)
            edfs_pkg::OP_LOAD: begin
                arrival_tbl[slot]   = arr;
                exec_tbl[slot]      = ex;
                deadline_tbl[slot]  = dl;
                remaining_tbl[slot] = ex;
                done_mask[slot]     = (ex == '0);
            end
            edfs_pkg::OP_TICK: begin
                // Earliest deadline among the arrived, unfinished tasks; lowest slot on a tie.
                pick = -1;
                for (int i = 0; i < used; i++) begin
                    if (!done_mask[i] && remaining_tbl[i] != '0 &&
                        CW'(arrival_tbl[i]) <= sched_time) begin
                        if (pick < 0 || deadline_tbl[i] < deadline_tbl[pick]) begin
                            pick = i;
                        end
                    end
                end
                if (pick < 0) begin
                    r.idle = 1'b1;
                end else begin
                    r.running_task = edfs_pkg::RUN_W'(pick + 1);
                    remaining_tbl[pick] = remaining_tbl[pick] - 1'b1;
                    if (remaining_tbl[pick] == '0) begin
                        done_mask[pick] = 1'b1;
                        r.task_finished = 1'b1;
                    end
                end
                if (sched_time != '1) begin
                    sched_time = sched_time + 1'b1;
                end
            end
            edfs_pkg::OP_CHECK: begin
                // Sum of exec/deadline with 16 fraction bits, each term truncated.
                util_sum = '0;
                zero_dl = 1'b0;
                for (int i = 0; i < used; i++) begin
                    if (deadline_tbl[i] == '0) begin
                        zero_dl = 1'b1;
                    end else begin
                        util_sum += {32'd0, exec_tbl[i], 16'd0} / {48'd0, deadline_tbl[i]};
                    end
                end
                r.feasible = !zero_dl && (util_sum <= 64'(edfs_pkg::FRAC_ONE));
            end
            default: begin
                // The unused code leaves the state alone.
            end
        endcase
        done_cnt = 0;
        for (int i = 0; i < used; i++) begin
            if (done_mask[i]) begin
                done_cnt++;
            end
        end
        r.all_finished = (done_cnt == used);
        r.current_time = sched_time;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [CW-1:0] want,
                                        input logic [CW-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Track every handshake at the clock edge where it completes.
    always @(posedge i_clk) begin
        t_sched_rsp got;
        t_sched_rsp want;
        if (!i_rst_n) begin
            done_mask    = '0;
            sched_time   = '0;
            task_count_q = edfs_pkg::TASK_COUNT_RST;
            expected_rsp_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                task_count_q = cfg.task_count;
            end
            if (req.valid && req.ready) begin
                expected_rsp_q.push_back(schedule_request(req.operation, req.slot,
                                                          req.arrival, req.exec_units,
                                                          req.deadline));
            end
            if (rsp.valid && rsp.ready) begin
                got.running_task  = rsp.running_task;
                got.idle          = rsp.idle;
                got.task_finished = rsp.task_finished;
                got.all_finished  = rsp.all_finished;
                got.current_time  = rsp.current_time;
                got.feasible      = rsp.feasible;
                if (expected_rsp_q.size() == 0) begin
                    $error("response with no request waiting: running_task %0d, time %0d",
                           got.running_task, got.current_time);
                    o_fail_count++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("running_task", CW'(want.running_task),
                                CW'(got.running_task));
                    check_field("idle", CW'(want.idle), CW'(got.idle));
                    check_field("task_finished", CW'(want.task_finished),
                                CW'(got.task_finished));
                    check_field("all_finished", CW'(want.all_finished),
                                CW'(got.all_finished));
                    check_field("current_time", want.current_time, got.current_time);
                    check_field("feasible", CW'(want.feasible), CW'(got.feasible));
                end
            end
        end
        o_pending <= expected_rsp_q.size();
    end

endmodule

### bench/tb_edf_task_scheduler_top.sv
module tb_edf_task_scheduler_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPW   = edfs_pkg::OP_W;
    localparam int SLW   = edfs_pkg::SLOT_W;
    localparam int FW    = edfs_pkg::FIELD_W;
    localparam int NSLOT = edfs_pkg::MAX_TASKS_DEF;

    // Operation code that the block does not define.
    localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 72;
    // Longest check runs all 16 slots through the divider; any stray response shows up well inside this.
    localparam int DRAIN_CYCLES = 600;

    // Task count per phase, extremes and out-of-range values included.
    localparam logic [edfs_pkg::CNT_W-1:0] PHASE_COUNTS [PHASES] =
        '{5'd16, 5'd0, 5'd31, 5'd1, 5'd7, 5'd17, 5'd12, 5'd16};

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned req_idle_pct;
    int unsigned rsp_stall_pct;
    int unsigned ticks_sent;
    int unsigned items_sent;
    int unsigned cfg_writes;
    int unsigned op_sent [4];

    edfs_cfg_if cfg_ch ();
    edfs_req_if req_ch ();
    edfs_rsp_if rsp_ch ();

    always #5ns clk = ~clk;

    edf_task_scheduler_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    edfs_sched_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .cfg          (cfg_ch),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Response side: stall at the rate of the current phase.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Sends one request, with a random gap ahead of it, and returns once it is accepted.
    task automatic send_request(input logic [OPW-1:0] op, input logic [SLW-1:0] slot,
                                input logic [FW-1:0] arr, input logic [FW-1:0] ex,
                                input logic [FW-1:0] dl);
        if ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.slot       <= slot;
        req_ch.arrival    <= arr;
        req_ch.exec_units <= ex;
        req_ch.deadline   <= dl;
        do @(posedge clk); while (!req_ch.ready);
        op_sent[op]++;
        items_sent++;
        if (op == edfs_pkg::OP_TICK) begin
            ticks_sent++;
        end
    endtask

    // Request whose fields are all random apart from the operation.
    task automatic send_op(input logic [OPW-1:0] op);
        send_request(op, SLW'($urandom), FW'($urandom), FW'($urandom), FW'($urandom));
    endtask

    // Stops sending and waits until every response has been taken.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_task_count(input logic [edfs_pkg::CNT_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.task_count <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    // A task set that arrives around the current time, then a check, a run of ticks
    // and sometimes a second check.
    task automatic run_task_set();
        int unsigned    nload;
        int unsigned    roll;
        logic [FW-1:0]  ex;
        logic [FW-1:0]  dl;
        logic [SLW-1:0] slot;
        nload = $urandom_range(1, NSLOT);
        for (int k = 0; k < nload; k++) begin
            // Execution time: mostly short, now and then zero or very long.
            roll = $urandom_range(99);
            if (roll < 8) begin
                ex = '0;
            end else if (roll < 13) begin
                ex = FW'($urandom);
            end else begin
                ex = FW'($urandom_range(1, 4));
            end
            // Deadline: a small multiple of the execution time, sometimes zero or random.
            roll = $urandom_range(99);
            if (roll < 6) begin
                dl = '0;
            end else if (roll < 11) begin
                dl = FW'($urandom);
            end else begin
                dl = FW'(ex * $urandom_range(1, 20) + $urandom_range(0, 3));
            end
            slot = ($urandom_range(99) < 85) ? SLW'(k) : SLW'($urandom);
            send_request(edfs_pkg::OP_LOAD, slot, FW'(ticks_sent + $urandom_range(0, 6)),
                         ex, dl);
        end
        send_op(edfs_pkg::OP_CHECK);
        repeat ($urandom_range(4, 30)) send_op(edfs_pkg::OP_TICK);
        if ($urandom_range(1) == 1) begin
            send_op(edfs_pkg::OP_CHECK);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int unsigned phase_start;
        int unsigned mode;
        rst_n             <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.task_count <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= edfs_pkg::OP_LOAD;
        req_ch.slot       <= '0;
        req_ch.arrival    <= '0;
        req_ch.exec_units <= '0;
        req_ch.deadline   <= '0;
        req_idle_pct      = 0;
        rsp_stall_pct     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every slot before anything reads the table; slot 0 is done at load
        // and has a zero deadline, slot 15 holds the largest values.
        send_request(edfs_pkg::OP_LOAD, 4'd0, 16'd0, 16'd0, 16'd0);
        for (int k = 1; k < NSLOT - 1; k++) begin
            send_request(edfs_pkg::OP_LOAD, SLW'(k), FW'(k), FW'(k % 3 + 1),
                         FW'(10 + k % 4));
        end
        send_request(edfs_pkg::OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // With one slot in use: nothing ready, then a zero deadline makes the set infeasible.
        send_op(edfs_pkg::OP_TICK);
        send_op(edfs_pkg::OP_CHECK);
        send_request(OP_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Utilization of exactly one is still feasible.
        send_request(edfs_pkg::OP_LOAD, 4'd0, 16'd0, 16'd5, 16'd5);
        send_op(edfs_pkg::OP_CHECK);
        send_op(edfs_pkg::OP_TICK);
        // A task that has not arrived yet is skipped; 3/2 is over one.
        send_request(edfs_pkg::OP_LOAD, 4'd0, 16'hFFFF, 16'd3, 16'd2);
        send_op(edfs_pkg::OP_TICK);
        send_op(edfs_pkg::OP_CHECK);
        wait_drained();

        // Random phases, each with its own task count and handshake pacing.
        for (int p = 0; p < PHASES; p++) begin
            mode = p % 4;
            req_idle_pct  = (mode == 1) ? 73 : (mode == 3) ? 19 : 0;
            rsp_stall_pct = (mode == 2) ? 73 : (mode == 3) ? 19 : 0;
            write_task_count(PHASE_COUNTS[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 80) begin
                    run_task_set();
                end else begin
                    repeat (4) send_op(OPW'($urandom_range(0, 3)));
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d loads, %0d ticks, %0d checks and %0d requests with the unused code,",
                 op_sent[edfs_pkg::OP_LOAD], op_sent[edfs_pkg::OP_TICK],
                 op_sent[edfs_pkg::OP_CHECK], op_sent[OP_UNUSED]);
        $display("over %0d task count writes and four handshake pacing modes.", cfg_writes);
        if (fail_count == 0) begin
            $display("edf_task_scheduler_top regression: pass");
        end else begin
            $display("edf_task_scheduler_top regression: fail");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20ms;
        $display("edf_task_scheduler_top regression: fail");
        $finish;
    end

endmodule

### edf_task_scheduler_top.f
design/edfs_pkg.sv
design/edfs_req_if.sv
design/edfs_rsp_if.sv
design/edfs_cfg_if.sv
design/edfs_ram.sv
design/edfs_div.sv
design/edf_task_scheduler_top.sv
bench/edfs_sched_checker.sv
bench/tb_edf_task_scheduler_top.sv
